### design/ntc_pkg.sv
package ntc_pkg;

  localparam int NTC_POINTS = 14;
  localparam int RES_W      = 20;
  localparam int TEMP_W     = 15;
  localparam int SPAN_W     = 16;
  localparam int DT_W       = 11;
  localparam int RATIO_BITS = 16;
  localparam int RATIO_W    = RATIO_BITS + 1;

  localparam logic [RES_W-1:0] NTC_R [NTC_POINTS] = '{
    20'd105384, 20'd58245, 20'd33620, 20'd20174, 20'd12535, 20'd10000, 20'd8037,
    20'd5301,   20'd3588,  20'd2486,  20'd1759,  20'd1270,  20'd933,   20'd697
  };

  localparam logic signed [TEMP_W-1:0] NTC_T [NTC_POINTS] = '{
    -15'sd2000, -15'sd1000, 15'sd0,    15'sd1000, 15'sd2000, 15'sd2500, 15'sd3000,
    15'sd4000,  15'sd5000,  15'sd6000, 15'sd7000, 15'sd8000, 15'sd9000, 15'sd10000
  };

  localparam logic [1:0] REG_REFERENCE = 2'd0;
  localparam logic [1:0] REG_PULLUP    = 2'd1;

  typedef struct packed {
    logic                     fault;
    logic                     clamp;
    logic signed [TEMP_W-1:0] t_base;
    logic [DT_W-1:0]          dt;
  } seg_t;

endpackage

### design/ntc_div.sv
// Restoring divider, one quotient bit per register stage.
// The caller guarantees num < den * 2^Q_W.
module ntc_div #(
  parameter int NUM_W  = 45,
  parameter int DEN_W  = 25,
  parameter int Q_W    = 20,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int EXT_W = NUM_W + Q_W;

  logic              vld  [Q_W+1];
  logic [NUM_W-1:0]  rem  [Q_W+1];
  logic [DEN_W-1:0]  dreg [Q_W+1];
  logic [Q_W-1:0]    q    [Q_W+1];
  logic [SIDE_W-1:0] side [Q_W+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = num;
  assign dreg[0] = den;
  assign q[0]    = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [EXT_W-1:0] dsh;
    logic [EXT_W-1:0] rext;
    logic             ge;
    assign dsh  = EXT_W'(dreg[s]) << B;
    assign rext = EXT_W'(rem[s]);
    assign ge   = rext >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1]  <= ge ? NUM_W'(rext - dsh) : rem[s];
      dreg[s+1] <= dreg[s];
      q[s+1]    <= {q[s][Q_W-2:0], ge};
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = q[Q_W];
  assign out_side  = side[Q_W];

endmodule

### design/ntc_adc_to_temperature_top.sv
// Throughput: one item per cycle; busy is always low and start is never refused.
// The two dividers take one quotient bit per stage and set most of the latency.
// The receiver cannot stall; each result is shown for one cycle with done.
// Synchronous reset empties the pipeline and restores 3300 mV and 10000 ohms.
module ntc_adc_to_temperature_top #(
  parameter int ADC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ADC_BITS-1:0]               sample,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [19:0]                       cfg_data,
  output logic                              done,
  output logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi,
  output logic                              status
);

  localparam int N_W   = ADC_BITS + 13;
  localparam int NUM_W = N_W + 20;
  localparam int LAT   = 5 + ntc_pkg::RES_W + ntc_pkg::RATIO_W + 1;
  localparam logic [N_W-1:0] ADC_MAX = N_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam int SEG_W = $bits(ntc_pkg::seg_t);

  logic [12:0] reference_mv;
  logic [19:0] pullup_ohms;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv <= 13'd3300;
      pullup_ohms  <= 20'd10000;
    end else if (cfg_valid) begin
      case (cfg_index)
        ntc_pkg::REG_REFERENCE: reference_mv <= cfg_data[12:0];
        ntc_pkg::REG_PULLUP:    pullup_ohms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: node voltage as a fraction of full scale.
  logic           a_vld;
  logic [N_W-1:0] a_n, a_full, a_lim;
  logic           a_ref0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
    a_n    <= N_W'(sample) * N_W'(reference_mv);
    a_full <= N_W'(reference_mv) * ADC_MAX;
    a_lim  <= N_W'(reference_mv - 13'd1) * ADC_MAX;
    a_ref0 <= reference_mv == 13'd0;
  end

  // Stage B: rail test and the divider operands.
  logic             b_vld, b_fault;
  logic [NUM_W-1:0] b_num;
  logic [N_W-1:0]   b_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_fault <= (a_n <= ADC_MAX) || a_ref0 || (a_n >= a_lim) || (a_full <= a_n);
    b_num   <= NUM_W'(pullup_ohms) * NUM_W'(a_n);
    b_den   <= a_full - a_n;
  end

  // Stage C: a quotient of 2^20 or more saturates.
  logic             c_vld, c_fault, c_sat;
  logic [NUM_W-1:0] c_num;
  logic [N_W-1:0]   c_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_fault <= b_fault;
    c_sat   <= b_num >= (NUM_W'(b_den) << ntc_pkg::RES_W);
    c_num   <= b_num;
    c_den   <= b_den;
  end

  logic                     d_vld;
  logic [ntc_pkg::RES_W-1:0] d_q;
  logic [1:0]               d_side;

  ntc_div #(
    .NUM_W(NUM_W), .DEN_W(N_W), .Q_W(ntc_pkg::RES_W), .SIDE_W(2)
  ) u_res_div (
    .clk(clk), .rst(rst),
    .in_valid(c_vld),
    .num((c_sat || c_fault) ? '0 : c_num),
    .den(c_den),
    .in_side({c_fault, c_sat}),
    .out_valid(d_vld), .quot(d_q), .out_side(d_side)
  );

  // Segment search over the table.
  logic [ntc_pkg::RES_W-1:0]  r;
  ntc_pkg::seg_t              seg;
  logic [ntc_pkg::SPAN_W-1:0] rdiff, span;
  logic                       found;

  assign r = d_side[0] ? '1 : d_q;

  always_comb begin
    seg.fault  = d_side[1];
    seg.clamp  = 1'b0;
    seg.t_base = ntc_pkg::NTC_T[ntc_pkg::NTC_POINTS-1];
    seg.dt     = '0;
    rdiff      = '0;
    span       = 16'd1;
    found      = 1'b0;
    if (r >= ntc_pkg::NTC_R[0]) begin
      seg.clamp  = 1'b1;
      seg.t_base = ntc_pkg::NTC_T[0];
    end else if (r <= ntc_pkg::NTC_R[ntc_pkg::NTC_POINTS-1]) begin
      seg.clamp  = 1'b1;
    end else begin
      for (int i = 1; i < ntc_pkg::NTC_POINTS; i++) begin
        if (!found && r <= ntc_pkg::NTC_R[i-1] && r >= ntc_pkg::NTC_R[i]) begin
          found      = 1'b1;
          seg.t_base = ntc_pkg::NTC_T[i-1];
          seg.dt     = ntc_pkg::DT_W'(ntc_pkg::NTC_T[i] - ntc_pkg::NTC_T[i-1]);
          rdiff      = ntc_pkg::SPAN_W'(ntc_pkg::NTC_R[i-1] - r);
          span       = ntc_pkg::SPAN_W'(ntc_pkg::NTC_R[i-1] - ntc_pkg::NTC_R[i]);
        end
      end
    end
  end

  logic                       l_vld;
  ntc_pkg::seg_t              l_seg;
  logic [ntc_pkg::SPAN_W-1:0] l_rdiff, l_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_vld <= 1'b0;
    end else begin
      l_vld <= d_vld;
    end
    l_seg   <= seg;
    l_rdiff <= rdiff;
    l_span  <= span;
  end

  logic                        e_vld;
  logic [ntc_pkg::RATIO_W-1:0] e_ratio;
  logic [SEG_W-1:0]            e_side;
  ntc_pkg::seg_t               e_seg;

  ntc_div #(
    .NUM_W(ntc_pkg::SPAN_W + ntc_pkg::RATIO_BITS), .DEN_W(ntc_pkg::SPAN_W),
    .Q_W(ntc_pkg::RATIO_W), .SIDE_W(SEG_W)
  ) u_ratio_div (
    .clk(clk), .rst(rst),
    .in_valid(l_vld),
    .num({l_rdiff, ntc_pkg::RATIO_BITS'(0)}),
    .den(l_span),
    .in_side(l_seg),
    .out_valid(e_vld), .quot(e_ratio), .out_side(e_side)
  );

  assign e_seg = ntc_pkg::seg_t'(e_side);

  // Stage M: ratio times the segment's temperature step.
  localparam int PROD_W = ntc_pkg::RATIO_W + ntc_pkg::DT_W;
  logic              m_vld;
  logic [PROD_W-1:0] m_prod;
  ntc_pkg::seg_t     m_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= e_vld;
    end
    m_prod <= PROD_W'(e_ratio) * PROD_W'(e_seg.dt);
    m_seg  <= e_seg;
  end

  logic [PROD_W-1:0]          rounded;
  logic [ntc_pkg::TEMP_W-1:0] step;

  assign rounded = m_prod + PROD_W'(1 << (ntc_pkg::RATIO_BITS - 1));
  assign step    = ntc_pkg::TEMP_W'(rounded >> ntc_pkg::RATIO_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    status <= m_seg.fault;
    if (m_seg.fault) begin
      temperature_centi <= '0;
    end else if (m_seg.clamp) begin
      temperature_centi <= m_seg.t_base;
    end else begin
      temperature_centi <= m_seg.t_base + $signed(step);
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted item did not come out after the pipeline latency");
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> temperature_centi == '0)
    else $error("fault result carries a non-zero temperature");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> temperature_centi >= -15'sd2000 && temperature_centi <= 15'sd10000)
    else $error("temperature outside the table range");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without an accepted item");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int        LATENCY     = 43;
  localparam int        CYCLE_LIMIT = 400000;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic signed [ntc_pkg::TEMP_W-1:0] temp;
    logic                              fault;
  } reading_t;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [11:0]                       sample;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [1:0]                        cfg_index;
  logic [19:0]                       cfg_data;
  logic                              done;
  logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi;
  logic                              status;

  reading_t readings_due[$];
  int unsigned ref_mv_model;
  int unsigned pullup_model;
  int          errors;
  int          cycles;
  bit          gaps_on;

  ntc_adc_to_temperature_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .temperature_centi(temperature_centi),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Piecewise linear lookup of temperature from thermistor resistance.
  function automatic logic signed [ntc_pkg::TEMP_W-1:0] resistance_to_centi(
    longint unsigned r);
    longint unsigned rc, rh, span, ratio, dt, step;
    if (r >= ntc_pkg::NTC_R[0]) return ntc_pkg::NTC_T[0];
    if (r <= ntc_pkg::NTC_R[ntc_pkg::NTC_POINTS-1]) return ntc_pkg::NTC_T[ntc_pkg::NTC_POINTS-1];
    for (int i = 1; i < ntc_pkg::NTC_POINTS; i++) begin
      rc = ntc_pkg::NTC_R[i-1];
      rh = ntc_pkg::NTC_R[i];
      if (r <= rc && r >= rh) begin
        span = rc - rh;
        if (span == 0) return ntc_pkg::NTC_T[i-1];
        ratio = ((rc - r) << ntc_pkg::RATIO_BITS) / span;
        dt    = longint'(ntc_pkg::NTC_T[i]) - longint'(ntc_pkg::NTC_T[i-1]);
        step  = (ratio * dt + (64'd1 << (ntc_pkg::RATIO_BITS - 1))) >> ntc_pkg::RATIO_BITS;
        return ntc_pkg::TEMP_W'(longint'(ntc_pkg::NTC_T[i-1]) + longint'(step));
      end
    end
    return ntc_pkg::NTC_T[ntc_pkg::NTC_POINTS-1];
  endfunction

  function automatic reading_t sample_to_reading(logic [11:0] raw);
    reading_t        rd;
    longint unsigned n, full, r;
    n    = longint'(raw) * ref_mv_model;
    full = longint'(ref_mv_model) * 4095;
    rd.fault = (n <= 4095) || (ref_mv_model < 1) || (n >= (ref_mv_model - 1) * 4095)
               || (full <= n);
    rd.temp = '0;
    if (!rd.fault) begin
      r = (longint'(pullup_model) * n) / (full - n);
      if (r > 64'hFFFFF) r = 64'hFFFFF;
      rd.temp = resistance_to_centi(r);
    end
    return rd;
  endfunction

  // Results are checked at the edge that ends their cycle; accepted items are
  // predicted at the edge that takes them.
  always @(posedge clk) begin
    reading_t want;
    if (!rst) begin
      if (done) begin
        if (readings_due.size() == 0) begin
          $display("%0t: result with none expected: temp %0d status %0b",
                   $time, temperature_centi, status);
          errors++;
        end else begin
          want = readings_due.pop_front();
          if (temperature_centi !== want.temp) begin
            $display("%0t: temperature_centi expected %0d actual %0d",
                     $time, want.temp, temperature_centi);
            errors++;
          end
          if (status !== want.fault) begin
            $display("%0t: status expected %0b actual %0b", $time, want.fault, status);
            errors++;
          end
        end
      end
      if (start && !busy) readings_due.push_back(sample_to_reading(sample));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_sample(logic [11:0] value);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 22) begin
      start = 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    start  = 1'b1;
    sample = value;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    start = 1'b0;
    wait (readings_due.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [19:0] value);
    drain_pipeline();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (index == ntc_pkg::REG_REFERENCE) ref_mv_model = value & 20'h01FFF;
    else if (index == ntc_pkg::REG_PULLUP) pullup_model = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [11:0] random_sample();
    case ($urandom_range(3))
      0: return 12'($urandom_range(8));
      1: return 12'd4095 - 12'($urandom_range(8));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  task automatic test_directed_samples();
    logic [11:0] picks [14] = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd4092, 12'd4093,
                                12'd4094, 12'd4095, 12'h555, 12'hAAA, 12'd2048,
                                12'd200, 12'd3900};
    foreach (picks[i]) send_sample(picks[i]);
  endtask

  task automatic test_rail_config_extremes();
    write_register(ntc_pkg::REG_REFERENCE, 20'd0);
    send_sample(12'd2048);
    send_sample(12'd4095);
    write_register(ntc_pkg::REG_REFERENCE, 20'd1);
    send_sample(12'd2048);
    write_register(ntc_pkg::REG_REFERENCE, 20'hFE000 | 20'd3300);
    send_sample(12'd2048);
    write_register(REG_SPARE_A, 20'd77);
    write_register(REG_SPARE_B, 20'hFFFFF);
    send_sample(12'd1000);
    write_register(ntc_pkg::REG_PULLUP, 20'd0);
    send_sample(12'd3000);
    write_register(ntc_pkg::REG_PULLUP, 20'hFFFFF);
    send_sample(12'd4000);
    send_sample(12'd10);
  endtask

  task automatic test_random_settings();
    logic [19:0] refs [8]    = '{20'd1000, 20'd5000, 20'd3300, 20'd2500, 20'd1000,
                                 20'd5000, 20'd8191, 20'd4096};
    logic [19:0] pullups [8] = '{20'd100, 20'd1000000, 20'd10000, 20'd4700,
                                 20'd1000000, 20'd100, 20'd33000, 20'd1500};
    for (int p = 0; p < 8; p++) begin
      write_register(ntc_pkg::REG_REFERENCE, refs[p]);
      write_register(ntc_pkg::REG_PULLUP, pullups[p]);
      gaps_on = (p != 2);
      repeat (200) send_sample(random_sample());
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; sample = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; cycles = 0; gaps_on = 1'b1;
    ref_mv_model = 3300; pullup_model = 10000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_samples();
    test_rail_config_extremes();
    test_random_settings();
    drain_pipeline();
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

### filelist.f
design/ntc_pkg.sv
design/ntc_div.sv
design/ntc_adc_to_temperature_top.sv
tb/sv/tb.sv
